### design/knp_pkg.sv
`default_nettype none

package knp_pkg;

    localparam int DIM_MAX    = 4;
    localparam int K_MAX      = 16;
    localparam int COORD_BITS = 16;

    localparam int NUM_COORD  = 4;
    localparam int FIELD_W    = 16;
    localparam int IDX_W      = 16;
    localparam int DIST_W     = 2 * COORD_BITS + $clog2(DIM_MAX);
    localparam int SQ_W       = 2 * COORD_BITS;
    localparam int K_W        = $clog2(K_MAX + 1);
    localparam int DIMS_W     = 3;
    localparam int KREG_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef t_coord [NUM_COORD-1:0] t_coords;

    // one kept neighbor, as held by a cell of the chain
    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] sq_dist;
        logic [IDX_W-1:0]  idx;
        t_coords           coords;
    } t_entry;

    // a point with its distance, on its way into the chain
    typedef struct packed {
        logic   last;
        t_entry entry;
    } t_item;

    typedef struct packed {
        logic insert;
        logic drain;
    } t_cell_ctl;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUERY_X0   = 3'd0,
        REG_QUERY_X1   = 3'd1,
        REG_QUERY_X2   = 3'd2,
        REG_QUERY_X3   = 3'd3,
        REG_DIMS_USED  = 3'd4,
        REG_NEIGHBOURS = 3'd5
    } t_cfg_reg;

    // order by distance, then by point index; equal keys count as "before"
    function automatic logic key_le(
        input logic [DIST_W-1:0] da,
        input logic [IDX_W-1:0]  ia,
        input logic [DIST_W-1:0] db,
        input logic [IDX_W-1:0]  ib
    );
        key_le = (da < db) || ((da == db) && (ia <= ib));
    endfunction

endpackage

`default_nettype wire

### design/knp_dist.sv
`default_nettype none

module knp_dist
    import knp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire t_coords              i_coords,
    input  wire logic [IDX_W-1:0]     i_idx,
    input  wire logic                 i_last,
    input  wire t_coords              i_query,
    input  wire logic [NUM_COORD-1:0] i_dim_en,
    output t_item                     o_item,
    output logic                      o_last_pending
);

    logic [COORD_BITS:0]   w_diff [NUM_COORD];
    logic [COORD_BITS-1:0] w_mag  [NUM_COORD];
    logic [SQ_W-1:0]       n_sq   [NUM_COORD];
    logic [DIST_W-1:0]     n_sum;

    logic                  r_a_valid;
    logic                  r_a_last;
    logic [IDX_W-1:0]      r_a_idx;
    t_coords               r_a_coords;
    logic [SQ_W-1:0]       r_sq   [NUM_COORD];
    t_item                 r_b;

    // stage A: per-dimension difference magnitude and square
    always_comb begin
        for (int j = 0; j < NUM_COORD; j++) begin
            w_diff[j] = {i_coords[j][COORD_BITS-1], i_coords[j]}
                      - {i_query[j][COORD_BITS-1], i_query[j]};
            w_mag[j]  = w_diff[j][COORD_BITS] ? COORD_BITS'(-w_diff[j])
                                              : w_diff[j][COORD_BITS-1:0];
            n_sq[j]   = i_dim_en[j] ? SQ_W'(w_mag[j]) * SQ_W'(w_mag[j]) : '0;
        end
    end

    // stage B: add the squares
    always_comb begin
        n_sum = '0;
        for (int j = 0; j < NUM_COORD; j++) begin
            n_sum = n_sum + DIST_W'(r_sq[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid       <= 1'b0;
            r_b.entry.valid <= 1'b0;
        end else begin
            r_a_valid       <= i_fire;
            r_b.entry.valid <= r_a_valid;
        end
        r_a_last          <= i_last;
        r_a_idx           <= i_idx;
        r_a_coords        <= i_coords;
        r_sq              <= n_sq;
        r_b.last          <= r_a_last;
        r_b.entry.sq_dist <= n_sum;
        r_b.entry.idx     <= r_a_idx;
        r_b.entry.coords  <= r_a_coords;
    end

    assign o_item         = r_b;
    assign o_last_pending = (r_a_valid && r_a_last) || (r_b.entry.valid && r_b.last);

endmodule

`default_nettype wire

### design/knp_cell.sv
`default_nettype none

module knp_cell
    import knp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire logic      i_in_k,
    input  wire t_entry    i_new,
    input  wire t_entry    i_left,
    input  wire logic      i_left_le,
    input  wire t_entry    i_right,
    output t_entry         o_entry,
    output logic           o_le
);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_eff;

    assign w_eff = r_entry.valid && i_in_k;
    assign o_le  = w_eff && key_le(r_entry.sq_dist, r_entry.idx, i_new.sq_dist, i_new.idx);

    always_comb begin
        n_entry = r_entry;
        priority if (i_ctl.drain) begin
            n_entry = i_right;
        end else if (i_ctl.insert) begin
            priority if (o_le) begin
                n_entry = r_entry;
            end else if (i_left_le) begin
                n_entry       = i_new;
                n_entry.valid = i_in_k;
            end else begin
                n_entry       = i_left;
                n_entry.valid = i_left.valid && i_in_k;
            end
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.sq_dist <= n_entry.sq_dist;
        r_entry.idx     <= n_entry.idx;
        r_entry.coords  <= n_entry.coords;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

### design/streaming_k_nearest_points_unit.sv
`default_nettype none

// Streaming k-nearest-neighbor search over points of up to four dimensions.
// Configure the query point, the number of dimensions and k through the write
// port while the block is idle. Then send data points on the input channel,
// one word per point; the word with i_last_point set closes the query.
// Every point reaches the sorted chain through registered steps: the
// per-dimension squares, their sum, and the insertion, during which
// all cells compare against the new key at once and shift behind it. The input
// channel takes one word per cycle while a query is being collected.
// After the last point, the first result word shows on o_valid once that point
// is in the chain and the head cell is loaded; the kept points follow in
// ascending order of (distance, index), one word per cycle, the last one
// flagged by o_final_result. The chain drains one cell per delivered word, so a stall on
// i_stall simply holds the output word and the chain.
// The input channel is stalled from the last point until the final word of
// the report has been loaded into the output register; the chain is then empty.
// Reset clears the kept list and output valid, and sets the query to the
// origin, four dimensions and k of one.
module streaming_k_nearest_points_unit
    import knp_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,

    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,

    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic signed [FIELD_W-1:0] i_coord_0,
    input  wire logic signed [FIELD_W-1:0] i_coord_1,
    input  wire logic signed [FIELD_W-1:0] i_coord_2,
    input  wire logic signed [FIELD_W-1:0] i_coord_3,
    input  wire logic [IDX_W-1:0]        i_point_index,
    input  wire logic                    i_last_point,

    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [IDX_W-1:0]             o_near_index,
    output logic [DIST_W-1:0]            o_near_distance,
    output logic signed [FIELD_W-1:0]    o_near_x0,
    output logic signed [FIELD_W-1:0]    o_near_x1,
    output logic signed [FIELD_W-1:0]    o_near_x2,
    output logic signed [FIELD_W-1:0]    o_near_x3,
    output logic                         o_final_result
);

    typedef enum logic {
        ST_COLLECT,
        ST_REPORT
    } t_state;

    // configuration
    t_coords           r_query;
    logic [DIMS_W-1:0] r_dims;
    logic [KREG_W-1:0] r_k;

    logic [K_W-1:0]       w_k;
    logic [NUM_COORD-1:0] w_dim_en;

    // input and distance pipeline
    logic    w_fire;
    t_coords w_coords;
    t_item   w_item;
    logic    w_last_pending;

    // chain
    t_cell_ctl      w_ctl;
    t_entry         w_cell  [K_MAX];
    t_entry         w_left  [K_MAX];
    t_entry         w_right [K_MAX];
    logic [K_MAX-1:0] w_le;
    logic [K_MAX-1:0] w_left_le;
    logic [K_MAX-1:0] w_in_k;

    // control and output register
    t_state r_state;
    logic   r_o_valid;
    t_entry r_o_entry;
    logic   r_o_final;
    logic   w_load;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query <= '0;
            r_dims  <= DIMS_W'(4);
            r_k     <= KREG_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_QUERY_X0:   r_query[0] <= t_coord'(i_cfg_data[COORD_BITS-1:0]);
                REG_QUERY_X1:   r_query[1] <= t_coord'(i_cfg_data[COORD_BITS-1:0]);
                REG_QUERY_X2:   r_query[2] <= t_coord'(i_cfg_data[COORD_BITS-1:0]);
                REG_QUERY_X3:   r_query[3] <= t_coord'(i_cfg_data[COORD_BITS-1:0]);
                REG_DIMS_USED:  r_dims     <= i_cfg_data[DIMS_W-1:0];
                REG_NEIGHBOURS: r_k        <= i_cfg_data[KREG_W-1:0];
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    // clamp k and the dimension count into range; zero acts as one
    always_comb begin
        int d;
        int k;
        d = int'(r_dims);
        k = int'(r_k);
        if (d == 0) d = 1;
        if (d > DIM_MAX) d = DIM_MAX;
        if (k == 0) k = 1;
        if (k > K_MAX) k = K_MAX;
        w_k = K_W'(k);
        for (int j = 0; j < NUM_COORD; j++) begin
            w_dim_en[j] = (j < d);
        end
    end

    assign w_fire = i_valid && !o_stall;

    // keep the low COORD_BITS of each coordinate
    assign w_coords[0] = t_coord'(i_coord_0[COORD_BITS-1:0]);
    assign w_coords[1] = t_coord'(i_coord_1[COORD_BITS-1:0]);
    assign w_coords[2] = t_coord'(i_coord_2[COORD_BITS-1:0]);
    assign w_coords[3] = t_coord'(i_coord_3[COORD_BITS-1:0]);

    knp_dist u_dist (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_coords       (w_coords),
        .i_idx          (i_point_index),
        .i_last         (i_last_point),
        .i_query        (r_query),
        .i_dim_en       (w_dim_en),
        .o_item         (w_item),
        .o_last_pending (w_last_pending)
    );

    // the report drains the chain one cell toward the head per output word
    assign w_load       = (r_state == ST_REPORT) && (!r_o_valid || !i_stall);
    assign w_ctl.insert = w_item.entry.valid;
    assign w_ctl.drain  = w_load;

    for (genvar g = 0; g < K_MAX; g++) begin : g_cell
        assign w_in_k[g] = (K_W'(g) < w_k);

        if (g == 0) begin : g_head
            assign w_left[g]    = '0;
            assign w_left_le[g] = 1'b1;
        end else begin : g_body
            assign w_left[g]    = w_cell[g-1];
            assign w_left_le[g] = w_le[g-1];
        end

        if (g == K_MAX - 1) begin : g_tail
            assign w_right[g] = '0;
        end else begin : g_mid
            assign w_right[g] = w_cell[g+1];
        end

        knp_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_in_k    (w_in_k[g]),
            .i_new     (w_item.entry),
            .i_left    (w_left[g]),
            .i_left_le (w_left_le[g]),
            .i_right   (w_right[g]),
            .o_entry   (w_cell[g]),
            .o_le      (w_le[g])
        );
    end

    // report control and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_COLLECT;
            r_o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_COLLECT: begin
                    if (w_item.entry.valid && w_item.last) begin
                        r_state <= ST_REPORT;
                    end
                end
                ST_REPORT: begin
                    // the head is last once the cell behind it is empty
                    if (w_load && !w_right[0].valid) begin
                        r_state <= ST_COLLECT;
                    end
                end
                default: r_state <= ST_COLLECT;
            endcase

            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end

        if (w_load) begin
            r_o_entry <= w_cell[0];
            r_o_final <= !w_right[0].valid;
        end
    end

    assign o_stall         = (r_state == ST_REPORT) || w_last_pending;
    assign o_valid         = r_o_valid;
    assign o_near_index    = r_o_entry.idx;
    assign o_near_distance = r_o_entry.sq_dist;
    assign o_near_x0       = FIELD_W'(r_o_entry.coords[0]);
    assign o_near_x1       = FIELD_W'(r_o_entry.coords[1]);
    assign o_near_x2       = FIELD_W'(r_o_entry.coords[2]);
    assign o_near_x3       = FIELD_W'(r_o_entry.coords[3]);
    assign o_final_result  = r_o_final;

endmodule

`default_nettype wire

### design/knp_checker.sv
`default_nettype none

module knp_checker
    import knp_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              o_stall,
    input wire logic              i_last_point,
    input wire logic              o_valid,
    input wire logic              i_stall,
    input wire logic [IDX_W-1:0]  o_near_index,
    input wire logic [DIST_W-1:0] o_near_distance,
    input wire logic              o_final_result
);

    // no output word straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> !o_valid)
        else $error("output word valid right after reset");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_near_index)
            && $stable(o_near_distance) && $stable(o_final_result)))
        else $error("stalled output word changed");

    // points of the next query wait until the report is finished
    a_stall_in_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_final_result) |-> o_stall)
        else $error("input open while a report is still in progress");

    // the input is closed right after the last point is taken
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_last_point) |=> o_stall)
        else $error("input open right after the last point");

endmodule

bind streaming_k_nearest_points_unit knp_checker u_knp_checker (.*);

`default_nettype wire
